// ===== rtl/core/header_length_sum_framer_unit_macros.svh =====
// Assertion helpers used by the framer RTL.
`ifndef HEADER_LENGTH_SUM_FRAMER_UNIT_MACROS_SVH
`define HEADER_LENGTH_SUM_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HLSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HLSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hlsf_pkg.sv =====
package hlsf_pkg;

  localparam logic [7:0]  HeadHi        = 8'hFE;
  localparam logic [7:0]  HeadLo        = 8'hEF;
  localparam logic [15:0] FrameOverhead = 16'd5;
  localparam logic [7:0]  HeadSum       = 8'(HeadHi + HeadLo);

  typedef logic [2:0] hlsf_idx_t;

  // Position within the results of one request.
  localparam hlsf_idx_t IdxHeadHi = 3'd0;
  localparam hlsf_idx_t IdxHeadLo = 3'd1;
  localparam hlsf_idx_t IdxLenHi  = 3'd2;
  localparam hlsf_idx_t IdxLenLo  = 3'd3;
  localparam hlsf_idx_t IdxData   = 3'd4;
  localparam hlsf_idx_t IdxSum    = 3'd5;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [15:0] total;
    logic [7:0]  sum;
  } hlsf_run_t;

endpackage

// ===== rtl/core/hlsf_if.sv =====
interface hlsf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;

  modport source (output valid, output payload_byte, output payload_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface hlsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       run_end;

  modport source (output valid, output frame_byte, output frame_end, output run_end,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_end, input run_end,
                  output ready);
endinterface

// ===== rtl/core/header_length_sum_framer_unit.sv =====
// The first result is registered and appears in the cycle after the request is accepted.
// Throughput: one result per cycle while the output is ready; a packet's first byte
// yields five results (six if it is also the last), a middle byte one, the final byte two.
// The next request is taken in the cycle the last result of the previous one leaves.
// Reset (asynchronous, active low) returns to awaiting a packet's first byte.
`include "header_length_sum_framer_unit_macros.svh"

module header_length_sum_framer_unit import hlsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlsf_in_if.sink    in_i,
  hlsf_out_if.source out_o
);

  logic [15:0] bytes_taken_q, bytes_taken_d;
  logic [15:0] held_length_q, held_length_d;
  logic [7:0]  running_sum_q, running_sum_d;

  logic        accept;
  logic        first;
  logic        last;
  logic [15:0] len;
  logic [15:0] total;
  logic [15:0] next_count;
  logic [7:0]  base_sum;
  logic [7:0]  new_sum;
  logic        free;
  hlsf_run_t   run;

  assign accept     = in_i.valid && free;
  assign first      = (bytes_taken_q == '0);
  assign len        = first ? in_i.payload_length : held_length_q;
  assign total      = len + FrameOverhead;
  assign next_count = bytes_taken_q + 16'd1;
  assign last       = (next_count == len);
  // Header and length bytes enter the checksum on the first byte only.
  assign base_sum   = first ? 8'(HeadSum + total[15:8] + total[7:0]) : running_sum_q;
  assign new_sum    = base_sum + in_i.payload_byte;

  assign run.first = first;
  assign run.last  = last;
  assign run.data  = in_i.payload_byte;
  assign run.total = total;
  assign run.sum   = new_sum;

  always_comb begin
    bytes_taken_d = bytes_taken_q;
    held_length_d = held_length_q;
    running_sum_d = running_sum_q;
    if (accept) begin
      held_length_d = len;
      bytes_taken_d = last ? '0 : next_count;
      running_sum_d = last ? '0 : new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_taken_q <= '0;
      held_length_q <= '0;
      running_sum_q <= '0;
    end else begin
      bytes_taken_q <= bytes_taken_d;
      held_length_q <= held_length_d;
      running_sum_q <= running_sum_d;
    end
  end

  hlsf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .run_i       (run),
    .out_ready_i (out_o.ready),
    .free_o      (free),
    .out_valid_o (out_o.valid),
    .frame_byte_o(out_o.frame_byte),
    .frame_end_o (out_o.frame_end),
    .run_end_o   (out_o.run_end)
  );

  assign in_i.ready = free;

  `HLSF_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_o.valid, in_i.ready, "ready low with no result pending")
  `HLSF_ASSERT_IMPL(a_end_closes_run, clk_i, rst_ni, out_o.valid && out_o.frame_end, out_o.run_end, "frame end not on last result")
  `HLSF_ASSERT_NEXT(a_header_first, clk_i, rst_ni, accept && (bytes_taken_q == '0), out_o.valid && (out_o.frame_byte == HeadHi), "frame does not open with header")

endmodule

// ===== rtl/core/hlsf_emit.sv =====
module hlsf_emit import hlsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  hlsf_run_t  run_i,
  input  logic       out_ready_i,
  output logic       free_o,
  output logic       out_valid_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output logic       run_end_o
);

  logic      valid_q, valid_d;
  hlsf_idx_t idx_q, idx_d;
  hlsf_run_t run_q;
  logic      take;

  always_comb begin
    frame_byte_o = run_q.data;
    unique case (idx_q)
      IdxHeadHi: frame_byte_o = HeadHi;
      IdxHeadLo: frame_byte_o = HeadLo;
      IdxLenHi:  frame_byte_o = run_q.total[15:8];
      IdxLenLo:  frame_byte_o = run_q.total[7:0];
      IdxData:   frame_byte_o = run_q.data;
      IdxSum:    frame_byte_o = run_q.sum;
      default:   frame_byte_o = run_q.data;
    endcase
  end

  assign frame_end_o = (idx_q == IdxSum);
  assign run_end_o   = (idx_q == IdxSum) || ((idx_q == IdxData) && !run_q.last);
  assign out_valid_o = valid_q;
  assign take        = valid_q && out_ready_i;
  // Take a new request while the last result of the current one leaves.
  assign free_o      = !valid_q || (take && run_end_o);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = run_i.first ? IdxHeadHi : IdxData;
    end else if (take) begin
      if (run_end_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= IdxHeadHi;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

endmodule

// ===== tb/sv/header_length_sum_framer_unit_test.sv =====
`timescale 1ns / 100ps

module header_length_sum_framer_unit_test;
  import hlsf_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandomBytes = 340;
  localparam int unsigned QuietBytes = 40;

  // Tracks the framer state and holds the frame bytes still owed by the block.
  class frame_tracker;
    typedef struct {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       run_end;
    } frame_byte_t;

    logic [15:0] bytes_taken;
    logic [15:0] held_length;
    logic [7:0]  running_sum;
    frame_byte_t bytes_due[$];
    int unsigned mismatches;

    function new();
      bytes_taken = '0;
      held_length = '0;
      running_sum = '0;
      mismatches  = 0;
    endfunction

    function void emit(logic [7:0] value, logic closes);
      bytes_due.push_back('{frame_byte: value, frame_end: closes, run_end: 1'b0});
      running_sum = running_sum + value;
    endfunction

    function void take_payload_byte(logic [7:0] data, logic [15:0] len);
      logic [15:0] total;
      logic [15:0] next_taken;
      if (bytes_taken == 16'd0) begin
        held_length = len;
        total       = len + FrameOverhead;
        running_sum = '0;
        emit(HeadHi, 1'b0);
        emit(HeadLo, 1'b0);
        emit(total[15:8], 1'b0);
        emit(total[7:0], 1'b0);
      end
      emit(data, 1'b0);
      next_taken = bytes_taken + 16'd1;
      if (next_taken == held_length) begin
        emit(running_sum, 1'b1);
        bytes_taken = '0;
        running_sum = '0;
      end else begin
        bytes_taken = next_taken;
      end
      bytes_due[bytes_due.size() - 1].run_end = 1'b1;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_frame_byte(logic [7:0] frame_byte, logic frame_end, logic run_end);
      frame_byte_t want;
      if (bytes_due.size() == 0) begin
        report($sformatf("unexpected frame byte %02h", frame_byte));
      end else begin
        want = bytes_due.pop_front();
        if (frame_byte !== want.frame_byte)
          report($sformatf("frame_byte %02h, want %02h", frame_byte, want.frame_byte));
        if (frame_end !== want.frame_end)
          report($sformatf("frame_end %b, want %b", frame_end, want.frame_end));
        if (run_end !== want.run_end)
          report($sformatf("run_end %b, want %b", run_end, want.run_end));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  int unsigned stall_left;
  int unsigned random_bytes;
  int unsigned cycle_count;
  logic [15:0] pkt_len;

  hlsf_in_if  in_bus ();
  hlsf_out_if out_bus ();

  frame_tracker tracker = new();

  header_length_sum_framer_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        tracker.take_payload_byte(in_bus.payload_byte, in_bus.payload_length);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        tracker.check_frame_byte(out_bus.frame_byte, out_bus.frame_end, out_bus.run_end);
    end
  end

  // Hold ready low in random bursts, starting no new burst once the quiet tail starts.
  initial begin
    out_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input logic [7:0] data, input logic [15:0] len);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.payload_byte   <= data;
    in_bus.payload_length <= len;
    do @(posedge clk); while (!(in_bus.valid === 1'b1 && in_bus.ready === 1'b1));
  endtask

  // A fill below zero gives random payload bytes; a length of zero means 65536 bytes.
  task automatic send_packet(input logic [15:0] len, input int fill);
    int unsigned count;
    logic [7:0]  data;
    logic [15:0] len_field;
    count = (len == 16'd0) ? 65536 : int'(len);
    for (int unsigned i = 0; i < count; i++) begin
      data = (fill < 0) ? 8'($urandom) : 8'(fill);
      // length counts only on the first byte; drive noise on the rest
      len_field = (i == 0) ? len : 16'($urandom);
      send_request(data, len_field);
    end
  endtask

  initial begin
    quiet = 1'b0;
    random_bytes = 0;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.payload_byte <= '0;
    in_bus.payload_length <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short frames; in single-byte ones the first byte is also the last
    send_packet(16'd1, 8'h00);
    send_packet(16'd1, 8'hff);
    send_packet(16'd2, 8'hff);
    send_packet(16'd3, 8'h00);
    send_packet(16'd4, -1);
    send_packet(16'd1, -1);
    send_packet(16'd5, 8'h80);

    while (random_bytes < RandomBytes) begin
      pkt_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                            : 16'($urandom_range(1, 8));
      send_packet(pkt_len, -1);
      random_bytes += pkt_len;
    end

    quiet = 1'b1;
    random_bytes = 0;
    while (random_bytes < QuietBytes) begin
      pkt_len = 16'($urandom_range(1, 6));
      send_packet(pkt_len, -1);
      random_bytes += pkt_len;
    end
    in_bus.valid <= 1'b0;
    @(posedge clk);

    while (tracker.bytes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
